// ===== rtl/core/bvhs_pkg.sv =====
// shared constants and types for the dual-box slab test
`default_nettype none

package bvhs_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SLOT_W      = 32;
    localparam int BOUNDS_W    = 64;
    localparam int NUM_AXES    = 3;
    localparam int NUM_STAGES  = 7;
    localparam int BOX_STAGES  = 4;
    localparam int CFG_IDX_W   = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_RECIP_X,
        REG_RECIP_Y,
        REG_RECIP_Z,
        REG_NEAR
    } t_reg_idx;

    // ray held in configuration, index 0 is x
    typedef struct packed {
        logic [NUM_AXES-1:0][SLOT_W-1:0] origin;
        logic [NUM_AXES-1:0][SLOT_W-1:0] recip;
        logic [SLOT_W-1:0]               near;
    } t_ray;

endpackage

`default_nettype wire

// ===== rtl/core/bvhs_ifs.sv =====
// channel interfaces: node test input, test result and configuration write
`default_nettype none

interface bvhs_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] left_x_bounds;
    logic [63:0] left_y_bounds;
    logic [63:0] left_z_bounds;
    logic [63:0] right_x_bounds;
    logic [63:0] right_y_bounds;
    logic [63:0] right_z_bounds;
    logic signed [31:0] closest_distance;

    modport source (
        output valid, left_x_bounds, left_y_bounds, left_z_bounds,
               right_x_bounds, right_y_bounds, right_z_bounds, closest_distance,
        input  ready
    );
    modport sink (
        input  valid, left_x_bounds, left_y_bounds, left_z_bounds,
               right_x_bounds, right_y_bounds, right_z_bounds, closest_distance,
        output ready
    );
endinterface

interface bvhs_out_if;
    logic        valid;
    logic        ready;
    logic        left_hit;
    logic        right_hit;
    logic        right_nearer;
    logic signed [31:0] left_entry;
    logic signed [31:0] right_entry;

    modport source (
        output valid, left_hit, right_hit, right_nearer, left_entry, right_entry,
        input  ready
    );
    modport sink (
        input  valid, left_hit, right_hit, right_nearer, left_entry, right_entry,
        output ready
    );
endinterface

interface bvhs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bvhs_box_pipe.sv =====
// per-box front pipeline: scale bounds, subtract origin, order each slab
`default_nettype none

module bvhs_box_pipe #(
    parameter int COORD_WIDTH = bvhs_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = bvhs_pkg::FRAC_BITS
) (
    input  wire logic                                             i_clk,
    input  wire logic [bvhs_pkg::BOX_STAGES-1:0]                  i_en,
    input  wire bvhs_pkg::t_ray                                   i_ray,
    input  wire logic [bvhs_pkg::NUM_AXES-1:0][bvhs_pkg::BOUNDS_W-1:0] i_bounds,
    output logic [bvhs_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]        o_slab_lo,
    output logic [bvhs_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]        o_slab_hi
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * COORD_WIDTH;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [PW-1:0] r_prod [bvhs_pkg::NUM_AXES][2];
    logic signed [CW-1:0] r_scl  [bvhs_pkg::NUM_AXES][2];
    logic signed [CW-1:0] r_t    [bvhs_pkg::NUM_AXES][2];
    logic signed [CW-1:0] r_lo   [bvhs_pkg::NUM_AXES];
    logic signed [CW-1:0] r_hi   [bvhs_pkg::NUM_AXES];

    for (genvar a = 0; a < bvhs_pkg::NUM_AXES; a++) begin : g_axis
        logic signed [CW-1:0] w_r;
        logic signed [CW-1:0] w_o;

        assign w_r = $signed(i_ray.recip[a][CW-1:0]);
        assign w_o = $signed(i_ray.origin[a][CW-1:0]);

        for (genvar e = 0; e < 2; e++) begin : g_end
            logic signed [CW-1:0] w_b;
            logic signed [PW-1:0] w_shift;
            logic                 w_fits;
            logic signed [CW:0]   w_diff;

            assign w_b     = $signed(i_bounds[a][e*bvhs_pkg::SLOT_W +: CW]);
            assign w_shift = r_prod[a][e] >>> FRAC_BITS;
            assign w_fits  = (&w_shift[PW-1:CW-1]) || !(|w_shift[PW-1:CW-1]);
            assign w_diff  = {r_scl[a][e][CW-1], r_scl[a][e]} - {w_o[CW-1], w_o};

            // stage 1: full-width product
            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_prod[a][e] <= PW'(w_b) * PW'(w_r);
                end
            end

            // stage 2: floor shift and saturate
            always_ff @(posedge i_clk) begin
                if (i_en[1]) begin
                    if (w_fits) begin
                        r_scl[a][e] <= w_shift[CW-1:0];
                    end else begin
                        r_scl[a][e] <= w_shift[PW-1] ? C_MIN : C_MAX;
                    end
                end
            end

            // stage 3: subtract scaled origin and saturate
            always_ff @(posedge i_clk) begin
                if (i_en[2]) begin
                    if (w_diff[CW] == w_diff[CW-1]) begin
                        r_t[a][e] <= w_diff[CW-1:0];
                    end else begin
                        r_t[a][e] <= w_diff[CW] ? C_MIN : C_MAX;
                    end
                end
            end
        end

        // stage 4: order the slab ends
        always_ff @(posedge i_clk) begin
            if (i_en[3]) begin
                if (r_t[a][0] < r_t[a][1]) begin
                    r_lo[a] <= r_t[a][0];
                    r_hi[a] <= r_t[a][1];
                end else begin
                    r_lo[a] <= r_t[a][1];
                    r_hi[a] <= r_t[a][0];
                end
            end
        end

        assign o_slab_lo[a] = r_lo[a];
        assign o_slab_hi[a] = r_hi[a];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bvh_node_dual_box_slab_test.sv =====
// top level: ray against both child boxes of a bvh node, slab method
// usage:
//   i_cfg carries register writes (index, data); it is always ready and a beat
//   writes one ray register. indexes 0-2 scaled origin x/y/z, 3-5 reciprocal
//   direction x/y/z, 6 near distance. indexes past 6 are dropped. write only
//   while no node test is in flight.
//   i_in carries one node test per beat: six packed min/max bound pairs and
//   the closest distance so far. o_res returns one result beat per test, in
//   order: hit flags, right_nearer and the two entry distances.
// timing:
//   seven register stages (multiply, shift/saturate, origin subtract, slab
//   order, pair reduce, final reduce, compare). one test per cycle sustained
//   while o_res is not stalled; the 12 bound multipliers each take one beat
//   per cycle.
// reset and stall:
//   reset clears the ray registers and every stage valid bit. when o_res is
//   stalled, stages fill up from the output backwards; i_in.ready drops only
//   once all seven stages hold a beat. no beat is lost or repeated.
`default_nettype none

module bvh_node_dual_box_slab_test #(
    parameter int COORD_WIDTH = bvhs_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = bvhs_pkg::FRAC_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bvhs_cfg_if.sink    i_cfg,
    bvhs_in_if.sink     i_in,
    bvhs_out_if.source  o_res
);

    localparam int CW = COORD_WIDTH;
    localparam int NS = bvhs_pkg::NUM_STAGES;
    localparam int NA = bvhs_pkg::NUM_AXES;

    // ray registers
    bvhs_pkg::t_ray r_ray;

    // stage valid bits and per-stage load enables
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_adv;

    // closest distance rides along until the reduce stage
    logic signed [CW-1:0] r_close [bvhs_pkg::BOX_STAGES];

    logic [1:0][NA-1:0][bvhs_pkg::BOUNDS_W-1:0] w_bounds;
    logic [1:0][NA-1:0][CW-1:0] w_lo;
    logic [1:0][NA-1:0][CW-1:0] w_hi;
    logic signed [CW-1:0] w_near;

    logic signed [CW-1:0] r_ent_a [2];
    logic signed [CW-1:0] r_ent_b [2];
    logic signed [CW-1:0] r_ext_a [2];
    logic signed [CW-1:0] r_ext_b [2];
    logic signed [CW-1:0] r_ent   [2];
    logic signed [CW-1:0] r_ext   [2];
    logic                 r_hit   [2];
    logic signed [CW-1:0] r_entry [2];
    logic                 r_closer;

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray <= '0;
        end else if (i_cfg.valid) begin
            unique case (bvhs_pkg::t_reg_idx'(i_cfg.index))
                bvhs_pkg::REG_ORIGIN_X: r_ray.origin[0] <= i_cfg.data;
                bvhs_pkg::REG_ORIGIN_Y: r_ray.origin[1] <= i_cfg.data;
                bvhs_pkg::REG_ORIGIN_Z: r_ray.origin[2] <= i_cfg.data;
                bvhs_pkg::REG_RECIP_X:  r_ray.recip[0]  <= i_cfg.data;
                bvhs_pkg::REG_RECIP_Y:  r_ray.recip[1]  <= i_cfg.data;
                bvhs_pkg::REG_RECIP_Z:  r_ray.recip[2]  <= i_cfg.data;
                bvhs_pkg::REG_NEAR:     r_ray.near      <= i_cfg.data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    assign w_near = $signed(r_ray.near[CW-1:0]);

    // ------------------------------------------------------- pipeline control
    // a stage loads when it is empty or the stage after it moves
    always_comb begin
        w_adv[NS-1] = !r_v[NS-1] || o_res.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign i_in.ready  = w_adv[0];
    assign o_res.valid = r_v[NS-1];

    // closest distance delay line, stages 1 to 4
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_close[0] <= $signed(i_in.closest_distance[CW-1:0]);
        end
        for (int k = 1; k < bvhs_pkg::BOX_STAGES; k++) begin
            if (w_adv[k]) begin
                r_close[k] <= r_close[k-1];
            end
        end
    end

    // ------------------------------------------------------ box front ends
    assign w_bounds[0] = {i_in.left_z_bounds, i_in.left_y_bounds, i_in.left_x_bounds};
    assign w_bounds[1] = {i_in.right_z_bounds, i_in.right_y_bounds, i_in.right_x_bounds};

    for (genvar b = 0; b < 2; b++) begin : g_box
        logic signed [CW-1:0] w_lo0, w_lo1, w_lo2;
        logic signed [CW-1:0] w_hi0, w_hi1, w_hi2;
        logic signed [CW-1:0] w_close;

        bvhs_box_pipe #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_box (
            .i_clk     (i_clk),
            .i_en      (w_adv[bvhs_pkg::BOX_STAGES-1:0]),
            .i_ray     (r_ray),
            .i_bounds  (w_bounds[b]),
            .o_slab_lo (w_lo[b]),
            .o_slab_hi (w_hi[b])
        );

        assign w_lo0   = $signed(w_lo[b][0]);
        assign w_lo1   = $signed(w_lo[b][1]);
        assign w_lo2   = $signed(w_lo[b][2]);
        assign w_hi0   = $signed(w_hi[b][0]);
        assign w_hi1   = $signed(w_hi[b][1]);
        assign w_hi2   = $signed(w_hi[b][2]);
        assign w_close = r_close[bvhs_pkg::BOX_STAGES-1];

        // stage 5: entry is a max over four, exit a min over four; pairs first
        always_ff @(posedge i_clk) begin
            if (w_adv[4]) begin
                r_ent_a[b] <= (w_lo0 > w_lo1) ? w_lo0 : w_lo1;
                r_ent_b[b] <= (w_lo2 > w_near) ? w_lo2 : w_near;
                r_ext_a[b] <= (w_hi0 < w_hi1) ? w_hi0 : w_hi1;
                r_ext_b[b] <= (w_hi2 < w_close) ? w_hi2 : w_close;
            end
        end

        // stage 6: final entry and exit
        always_ff @(posedge i_clk) begin
            if (w_adv[5]) begin
                r_ent[b] <= (r_ent_a[b] > r_ent_b[b]) ? r_ent_a[b] : r_ent_b[b];
                r_ext[b] <= (r_ext_a[b] < r_ext_b[b]) ? r_ext_a[b] : r_ext_b[b];
            end
        end

        // stage 7: hit when the interval is not empty
        always_ff @(posedge i_clk) begin
            if (w_adv[6]) begin
                r_hit[b]   <= (r_ext[b] >= r_ent[b]);
                r_entry[b] <= r_ent[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_closer <= (r_ent[0] > r_ent[1]);
        end
    end

    // ---------------------------------------------------------------- result
    assign o_res.left_hit     = r_hit[0];
    assign o_res.right_hit    = r_hit[1];
    assign o_res.right_nearer = r_closer;
    assign o_res.left_entry   = 32'(r_entry[0]);
    assign o_res.right_entry  = 32'(r_entry[1]);

    // ------------------------------------------------------------ assertions
    // input backs off only when every stage holds a beat
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_v))
        else $error("input stalled with an empty stage");

    // an accepted beat occupies the first stage next cycle
    a_accept_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v[0])
        else $error("accepted beat lost at stage 1");

    // a beat moving out of stage 6 lands in the output register
    a_last_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-2] && w_adv[NS-1]) |=> o_res.valid)
        else $error("beat lost between final reduce and output");

endmodule

`default_nettype wire
